FILE: rtl/cartesian_to_spherical_assert.svh
// Assertion macros for the converter RTL.
// CTS_ASSERT_IMPL: same-cycle implication, CTS_ASSERT_NEXT: next-cycle implication.
`ifndef CARTESIAN_TO_SPHERICAL_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_ASSERT_SVH

`define CTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cartesian_to_spherical: assertion failed");

`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cartesian_to_spherical: assertion failed");

`endif

FILE: rtl/cts_pkg.sv
`default_nettype none

package cts_pkg;

	// vector datapath: inputs times 2^14, headroom for CORDIC gain
	localparam int VW = 34;
	// angle accumulator, radians Q16
	localparam int AW = 20;
	// magnitude into gain correction, unsigned
	localparam int MW = 31;
	// 1/K in Q0.30
	localparam int KW = 30;
	localparam int PW = MW + KW;

	localparam logic [KW-1:0] KINV = 30'd652032874;
	localparam logic signed [AW-1:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [AW-1:0] PI_Q14_A = 20'sd51472;
	localparam logic signed [16:0] AZ_PI = 17'sd51472;
	localparam logic [15:0] POL_PI = 16'd51472;
	localparam logic [MW-1:0] RAD_MAX = 31'd65535;

	localparam int ATAN_ENTRIES = 17;
	localparam logic signed [AW-1:0] ATAN_TBL [ATAN_ENTRIES] = '{
		20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
		20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
		20'sd16, 20'sd8, 20'sd4, 20'sd2, 20'sd1
	};

	// per-point data that rides along the pipeline
	typedef struct packed {
		logic              batch_end;
		logic              xy_zero;
		logic              all_zero;
		logic signed [15:0] z;
		logic signed [16:0] az;
		logic [15:0]       pol;
	} side_t;

	typedef struct packed {
		logic                valid;
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [AW-1:0] ang;
		side_t               side;
	} vec_t;

	typedef struct packed {
		logic          valid;
		logic [MW-1:0] mag;
		side_t         side;
	} mag_t;

	// atan(2^-step) in Q16, zero past the table
	function automatic logic signed [AW-1:0] atan_q16(input int step);
		logic [4:0] idx;
		idx = step[4:0];
		if (step < ATAN_ENTRIES) begin
			return ATAN_TBL[idx];
		end
		return '0;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/cts_prerot.sv
`default_nettype none

module cts_prerot (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid,
	input  logic signed [cts_pkg::VW-1:0] x,
	input  logic signed [cts_pkg::VW-1:0] y,
	input  cts_pkg::side_t               side,
	output cts_pkg::vec_t                q
);
	import cts_pkg::*;

	logic                valid_q;
	logic signed [VW-1:0] x_q, y_q;
	logic signed [AW-1:0] ang_q;
	side_t               side_q;

	logic signed [VW-1:0] x_c, y_c;
	logic signed [AW-1:0] ang_c;

	// fold the left half plane into the right one
	always_comb begin
		x_c   = x;
		y_c   = y;
		ang_c = '0;
		if (x < 0) begin
			if (y >= 0) begin
				x_c   = y;
				y_c   = -x;
				ang_c = HALF_PI_Q16;
			end else begin
				x_c   = -y;
				y_c   = x;
				ang_c = -HALF_PI_Q16;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= x_c;
			y_q    <= y_c;
			ang_q  <= ang_c;
			side_q <= side;
		end
	end

	assign q = '{valid: valid_q, x: x_q, y: y_q, ang: ang_q, side: side_q};

endmodule

`default_nettype wire

FILE: rtl/cts_cordic_cell.sv
`default_nettype none

module cts_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  cts_pkg::vec_t d,
	output cts_pkg::vec_t q
);
	import cts_pkg::*;

	localparam logic signed [AW-1:0] DA = atan_q16(STEP);

	logic                valid_q;
	logic signed [VW-1:0] x_q, y_q;
	logic signed [AW-1:0] ang_q;
	side_t               side_q;

	logic signed [VW-1:0] dx, dy;

	assign dx = d.y >>> STEP;
	assign dy = d.x >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	// one vectoring micro-rotation, steering y toward zero
	always_ff @(posedge clk) begin
		if (en) begin
			if (d.y >= 0) begin
				x_q   <= d.x + dx;
				y_q   <= d.y - dy;
				ang_q <= d.ang + DA;
			end else begin
				x_q   <= d.x - dx;
				y_q   <= d.y + dy;
				ang_q <= d.ang - DA;
			end
			side_q <= d.side;
		end
	end

	assign q = '{valid: valid_q, x: x_q, y: y_q, ang: ang_q, side: side_q};

endmodule

`default_nettype wire

FILE: rtl/cts_gain.sv
`default_nettype none

module cts_gain #(
	parameter int SHIFT = 30
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  cts_pkg::mag_t d,
	output cts_pkg::mag_t q
);
	import cts_pkg::*;

	localparam logic [PW:0] ROUND = (PW+1)'(1) << (SHIFT - 1);

	logic          valid_s1, valid_s2;
	logic [PW-1:0] prod_s1;
	side_t         side_s1, side_s2;
	logic [MW-1:0] mag_s2;

	logic [PW-1:0] prod_c;
	logic [PW:0]   sum_c;
	logic [PW:0]   shifted_c;

	assign prod_c    = PW'(d.mag) * PW'(KINV);
	assign sum_c     = {1'b0, prod_s1} + ROUND;
	assign shifted_c = sum_c >> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= d.valid;
			valid_s2 <= valid_s1;
		end
	end

	// multiply by 1/K, then round off the fraction
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_c;
			side_s1 <= d.side;
			mag_s2  <= shifted_c[MW-1:0];
			side_s2 <= side_s1;
		end
	end

	assign q = '{valid: valid_s2, mag: mag_s2, side: side_s2};

endmodule

`default_nettype wire

FILE: rtl/cartesian_to_spherical.sv
// Each point passes pre-rotation, CORDIC cells and gain correction twice, then the output register.
// Throughput: one point per cycle, set by the fully pipelined chain of CORDIC cells;
// every stage advances together whenever the output register is empty or being taken.
// Reset (arst_n low) clears only the stage valid bits; the data registers are not reset.
`default_nettype none

module cartesian_to_spherical #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	input  logic signed [15:0] coord_z,
	input  logic               batch_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        radius,
	output logic [15:0]        polar_angle,
	output logic signed [16:0] azimuth,
	output logic               batch_end_out
);
	import cts_pkg::*;

	`include "cartesian_to_spherical_assert.svh"

	logic en;

	vec_t c1 [CORDIC_STEPS+1];
	vec_t c2 [CORDIC_STEPS+1];
	mag_t g1_d, g1_q, g2_d, g2_q;

	logic signed [VW-1:0] x1_in, y1_in, x2_in, y2_in;
	side_t               side1;
	logic [MW-1:0]       rxy;

	logic signed [AW-1:0] az_r, pol_r;
	logic signed [16:0]   az_c;
	logic [15:0]          pol_c;

	logic               out_valid_q;
	logic [15:0]        radius_q, polar_angle_q;
	logic signed [16:0] azimuth_q;
	logic               batch_end_q;

	// global advance: the output register is free or being emptied
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// pass one input: (x, y) scaled to 14 fraction bits
	assign x1_in = VW'(coord_x) <<< 14;
	assign y1_in = VW'(coord_y) <<< 14;

	always_comb begin
		side1.batch_end = batch_end;
		side1.xy_zero   = (coord_x == '0) && (coord_y == '0);
		side1.all_zero  = side1.xy_zero && (coord_z == '0);
		side1.z         = coord_z;
		side1.az        = '0;
		side1.pol       = '0;
	end

	cts_prerot u_prerot1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(in_valid), .x(x1_in), .y(y1_in), .side(side1), .q(c1[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pass1
		cts_cordic_cell #(.STEP(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .d(c1[i]), .q(c1[i+1])
		);
	end

	// azimuth: Q16 to Q14 with rounding, clamp to +-pi
	always_comb begin
		az_r = (c1[CORDIC_STEPS].ang + AW'(2)) >>> 2;
		if (az_r > PI_Q14_A) begin
			az_r = PI_Q14_A;
		end else if (az_r < -PI_Q14_A) begin
			az_r = -PI_Q14_A;
		end
		az_c = c1[CORDIC_STEPS].side.xy_zero ? '0 : az_r[16:0];
	end

	always_comb begin
		g1_d.valid   = c1[CORDIC_STEPS].valid;
		g1_d.mag     = c1[CORDIC_STEPS].x[MW-1:0];
		g1_d.side    = c1[CORDIC_STEPS].side;
		g1_d.side.az = az_c;
	end

	cts_gain #(.SHIFT(30)) u_gain1 (
		.clk(clk), .arst_n(arst_n), .en(en), .d(g1_d), .q(g1_q)
	);

	// pass two input: (z, rxy)
	assign rxy   = g1_q.side.xy_zero ? '0 : g1_q.mag;
	assign x2_in = VW'(g1_q.side.z) <<< 14;
	assign y2_in = signed'({{(VW-MW){1'b0}}, rxy});

	cts_prerot u_prerot2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(g1_q.valid), .x(x2_in), .y(y2_in), .side(g1_q.side), .q(c2[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pass2
		cts_cordic_cell #(.STEP(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .d(c2[i]), .q(c2[i+1])
		);
	end

	// polar angle: round, clamp to 0..pi, zero at the origin
	always_comb begin
		pol_r = (c2[CORDIC_STEPS].ang + AW'(2)) >>> 2;
		if (pol_r > PI_Q14_A) begin
			pol_r = PI_Q14_A;
		end else if (pol_r < 0) begin
			pol_r = '0;
		end
		pol_c = c2[CORDIC_STEPS].side.all_zero ? '0 : pol_r[15:0];
	end

	always_comb begin
		g2_d.valid    = c2[CORDIC_STEPS].valid;
		g2_d.mag      = (c2[CORDIC_STEPS].x < 0) ? '0 : c2[CORDIC_STEPS].x[MW-1:0];
		g2_d.side     = c2[CORDIC_STEPS].side;
		g2_d.side.pol = pol_c;
	end

	cts_gain #(.SHIFT(44)) u_gain2 (
		.clk(clk), .arst_n(arst_n), .en(en), .d(g2_d), .q(g2_q)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= g2_q.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			radius_q      <= (g2_q.mag > RAD_MAX) ? RAD_MAX[15:0] : g2_q.mag[15:0];
			polar_angle_q <= g2_q.side.pol;
			azimuth_q     <= g2_q.side.az;
			batch_end_q   <= g2_q.side.batch_end;
		end
	end

	assign out_valid     = out_valid_q;
	assign radius        = radius_q;
	assign polar_angle   = polar_angle_q;
	assign azimuth       = azimuth_q;
	assign batch_end_out = batch_end_q;

	`CTS_ASSERT_IMPL(a_pol_range, clk, arst_n, out_valid_q, polar_angle_q <= POL_PI)
	`CTS_ASSERT_IMPL(a_az_range, clk, arst_n, out_valid_q,
		(azimuth_q <= AZ_PI) && (azimuth_q >= -AZ_PI))
	`CTS_ASSERT_IMPL(a_rxy_zero, clk, arst_n, g1_q.valid && g1_q.side.xy_zero, g1_q.mag == '0)
	`CTS_ASSERT_NEXT(a_stall_hold, clk, arst_n, !en,
		$stable(c2[CORDIC_STEPS].valid) && $stable(g1_q.valid))

endmodule

`default_nettype wire

FILE: verif/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CORDIC_STEPS = 16;
	localparam int RAND_POINTS = 1400;
	localparam int IDLE_LIMIT = 2000;
	// pipeline depth plus margin for the final drain
	localparam int DRAIN_CYCLES = 2 * CORDIC_STEPS + 30;
	localparam int PRINT_CAP = 40;

	// fixed-point constants of the conversion
	localparam longint HALF_PI_Q16 = 102944;
	localparam longint PI_Q14 = 51472;
	localparam longint KINV_Q30 = 652032874;
	localparam longint RADIUS_MAX = 65535;
	localparam int ATAN_LEN = 17;
	localparam longint ATAN_Q16 [ATAN_LEN] = '{
		51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1
	};
	localparam logic signed [15:0] EDGE_VALS [6] = '{
		-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
	};

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               last;
	} point_t;

	typedef struct packed {
		logic [15:0]        radius;
		logic [15:0]        polar;
		logic signed [16:0] az;
		logic               last;
	} sph_t;

	// one directed point; typed rows carry their result
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               last;
		logic               typed;
		logic [15:0]        radius;
		logic [15:0]        polar;
		logic signed [16:0] az;
	} row_t;

	localparam int DIR_LEN = 22;
	localparam row_t DIR_ROWS [DIR_LEN] = '{
		// origin: everything zero
		'{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 16'd0, 16'd0, 17'sd0},
		'{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 16'd0, 16'd0, 17'sd0},
		// axes, negative x axis gives azimuth +pi
		'{16'sd16384, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{-16'sd16384, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{16'sd0, 16'sd16384, 16'sd0, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{16'sd0, -16'sd16384, 16'sd0, 1'b1, 1'b0, 16'd0, 16'd0, 17'sd0},
		// z only: zero xy vector
		'{16'sd0, 16'sd0, 16'sd16384, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{16'sd0, 16'sd0, -16'sd16384, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{16'sd0, 16'sd0, 16'sd32767, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{16'sd0, 16'sd0, -16'sd32768, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		// field extremes
		'{16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{-16'sd32768, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{16'sd32767, -16'sd32768, 16'sd0, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{-16'sd32768, 16'sd32767, -16'sd32768, 1'b1, 1'b0, 16'd0, 16'd0, 17'sd0},
		// pre-rotation, both signs of y with x < 0
		'{-16'sd12000, 16'sd5000, 16'sd3000, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{-16'sd12000, -16'sd5000, -16'sd3000, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		// smallest nonzero magnitudes
		'{16'sd1, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{16'sd0, 16'sd0, 16'sd1, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{-16'sd1, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{-16'sd1, -16'sd1, -16'sd1, 1'b0, 1'b0, 16'd0, 16'd0, 17'sd0},
		'{16'sd1, 16'sd1, 16'sd1, 1'b1, 1'b0, 16'd0, 16'd0, 17'sd0}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] coord_x;
	logic signed [15:0] coord_y;
	logic signed [15:0] coord_z;
	logic               batch_end;
	logic               out_valid;
	logic               out_ready;
	logic [15:0]        radius;
	logic [15:0]        polar_angle;
	logic signed [16:0] azimuth;
	logic               batch_end_out;

	sph_t pending_results[$];
	int   mismatches = 0;
	int   results_checked = 0;
	int   points_sent = 0;
	int   idle_cycles = 0;
	bit   steady = 1'b0;

	cartesian_to_spherical #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.batch_end(batch_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.radius(radius),
		.polar_angle(polar_angle),
		.azimuth(azimuth),
		.batch_end_out(batch_end_out)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// CORDIC vectoring: rotates (x, y) onto the x axis, returns final x, angle in Q16
	function automatic longint cordic_vector(input longint xi, input longint yi,
			output longint ang);
		longint x, y, a, t, dx, dy;
		x = xi;
		y = yi;
		a = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				a = HALF_PI_Q16;
			end else begin
				x = -y;
				y = t;
				a = -HALF_PI_Q16;
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				a = a + ((i < ATAN_LEN) ? ATAN_Q16[i] : 0);
			end else begin
				x = x - dx;
				y = y + dy;
				a = a - ((i < ATAN_LEN) ? ATAN_Q16[i] : 0);
			end
		end
		ang = a;
		return x;
	endfunction

	// Q16 angle to Q14 with rounding, clamped to range
	function automatic longint q14_angle(input longint a, input longint lo, input longint hi);
		longint r;
		r = (a + 2) >>> 2;
		if (r < lo)
			r = lo;
		if (r > hi)
			r = hi;
		return r;
	endfunction

	function automatic sph_t to_spherical(input point_t p);
		sph_t   r;
		longint cx, cy, cz, ang, x1, x2, rxy, mag;
		bit     xy_zero;
		cx = longint'($signed(p.x));
		cy = longint'($signed(p.y));
		cz = longint'($signed(p.z));
		xy_zero = (cx == 0) && (cy == 0);
		r = '0;
		r.last = p.last;
		x1 = cordic_vector(cx * 16384, cy * 16384, ang);
		if (!xy_zero)
			r.az = 17'(q14_angle(ang, -PI_Q14, PI_Q14));
		// xy length, gain removed, still 14 fraction bits
		rxy = (x1 * KINV_Q30 + (longint'(1) << 29)) >>> 30;
		if (xy_zero)
			rxy = 0;
		if (!xy_zero || cz != 0) begin
			x2 = cordic_vector(cz * 16384, rxy, ang);
			r.polar = 16'(q14_angle(ang, 0, PI_Q14));
			if (x2 < 0)
				x2 = 0;
			mag = (x2 * KINV_Q30 + (longint'(1) << 43)) >>> 44;
			if (mag > RADIUS_MAX)
				mag = RADIUS_MAX;
			r.radius = 16'(mag);
		end
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		if (mismatches < PRINT_CAP)
			$display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int next_gap(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// present one word, hold it until taken, then queue its result
	task automatic send_point(input point_t p, input bit typed, input sph_t want);
		int gap;
		gap = next_gap(steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		coord_x <= p.x;
		coord_y <= p.y;
		coord_z <= p.z;
		batch_end <= p.last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(typed ? want : to_spherical(p));
		points_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// result side: random back-pressure, none while steady
	initial begin
		int hold;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = next_gap(steady);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		sph_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report("result word with no point pending", int'(radius), 0);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (radius !== want.radius)
					report("radius", int'(radius), int'(want.radius));
				if (polar_angle !== want.polar)
					report("polar_angle", int'(polar_angle), int'(want.polar));
				if (azimuth !== want.az)
					report("azimuth", int'(azimuth), int'(want.az));
				if (batch_end_out !== want.last)
					report("batch_end_out", int'(batch_end_out), int'(want.last));
			end
		end
	end

	// watchdog: no word moving on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
				$display("cartesian_to_spherical test failed");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		point_t p;
		sph_t   want;
		int     kind;
		int     mask;
		arst_n = 1'b0;
		in_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		batch_end = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed points
		foreach (DIR_ROWS[k]) begin
			p = '{DIR_ROWS[k].x, DIR_ROWS[k].y, DIR_ROWS[k].z, DIR_ROWS[k].last};
			want = '{DIR_ROWS[k].radius, DIR_ROWS[k].polar, DIR_ROWS[k].az,
				DIR_ROWS[k].last};
			send_point(p, DIR_ROWS[k].typed, want);
		end
		wait_drained();

		// random points in several shapes
		for (int n = 0; n < RAND_POINTS; n++) begin
			if (n % 200 == 0)
				steady = ($urandom_range(3) == 0);
			// pipeline fully drained once mid-run
			if (n == RAND_POINTS / 2)
				wait_drained();
			kind = $urandom_range(99);
			p.x = 16'($urandom);
			p.y = 16'($urandom);
			p.z = 16'($urandom);
			p.last = ($urandom_range(7) == 0);
			if (kind >= 50 && kind < 65) begin
				// small magnitudes: CORDIC near its resolution
				p.x = 16'(int'($urandom_range(128)) - 64);
				p.y = 16'(int'($urandom_range(128)) - 64);
				p.z = 16'(int'($urandom_range(128)) - 64);
			end else if (kind >= 65 && kind < 80) begin
				// some components zero, origin included
				mask = $urandom_range(1, 7);
				if (mask[0])
					p.x = '0;
				if (mask[1])
					p.y = '0;
				if (mask[2])
					p.z = '0;
			end else if (kind >= 80 && kind < 92) begin
				p.x = EDGE_VALS[$urandom_range(5)];
				p.y = EDGE_VALS[$urandom_range(5)];
				p.z = EDGE_VALS[$urandom_range(5)];
			end else if (kind >= 92) begin
				// negative x axis
				p.x = 16'(-int'($urandom_range(1, 32768)));
				p.y = '0;
			end
			send_point(p, 1'b0, '0);
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d points sent (%0d directed, rest random), %0d results checked",
			points_sent, DIR_LEN, results_checked);
		$display("%0d mismatches, %0d results still pending",
			mismatches, pending_results.size());
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("cartesian_to_spherical test passed");
		end else begin
			$display("cartesian_to_spherical test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/cts_pkg.sv
rtl/cts_prerot.sv
rtl/cts_cordic_cell.sv
rtl/cts_gain.sv
rtl/cartesian_to_spherical.sv
verif/tb.sv
